// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (!(cond))) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hw/rtl/actok_pkg.sv =====
// Shared types and constants for the assembler character tokenizer.
// No dependencies.
package actok_pkg;

  localparam int TEXT_BYTES  = 8;
  localparam int TEXT_W      = 8 * TEXT_BYTES;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] KIND_KEYWORD = 4'd0;
  localparam logic [3:0] KIND_LABEL   = 4'd1;
  localparam logic [3:0] KIND_IDENT   = 4'd2;
  localparam logic [3:0] KIND_LPAREN  = 4'd3;
  localparam logic [3:0] KIND_RPAREN  = 4'd4;
  localparam logic [3:0] KIND_COMMA   = 4'd5;
  localparam logic [3:0] KIND_POUND   = 4'd6;
  localparam logic [3:0] KIND_CONST   = 4'd7;
  localparam logic [3:0] KIND_INVALID = 4'd8;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_POUND  = 8'h23;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_COMMA  = 8'h2C;

  localparam logic [TEXT_W-1:0] KW_LDA = 64'h0000_0000_0041_444C;
  localparam logic [TEXT_W-1:0] KW_RTS = 64'h0000_0000_0053_5452;

  typedef struct packed {
    logic [3:0]        kind;
    logic [3:0]        length;
    logic              overflow;
    logic [TEXT_W-1:0] text;
    logic              last;
  } token_t;

  // up to two tokens leave the lexer per character, in order
  typedef struct packed {
    logic [1:0] n;
    token_t     t0;
    token_t     t1;
  } push_t;

endpackage

// ===== hw/rtl/actok_front.sv =====
// Lexer front end: takes one character per transfer, keeps the run state
// and emits zero to two tokens. Depends on actok_pkg and assert_macros.svh.
`include "assert_macros.svh"
module actok_front #(
  parameter int MAX_TOKEN_CHARS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          ch,
  input  logic                ch_valid,
  output logic                ch_ready,
  input  logic                room,
  output actok_pkg::push_t    push
);

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_WORD, MODE_DOLLAR, MODE_DIGITS, MODE_SKIP
  } mode_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  mode_t                        mode, mode_next;
  logic [actok_pkg::TEXT_W-1:0] text_buf, text_buf_next, app_text;
  logic [3:0]                   run_len, run_len_next, app_len;
  logic                         run_ovf, run_ovf_next, app_ovf;
  logic                         all_hex, all_hex_next;
  logic                         take, alnum, keyword, do_fresh;
  logic                         have_run, have_fresh;
  actok_pkg::token_t            run_tok, fresh_tok;

  assign ch_ready = room;
  assign take     = ch_valid & room;
  assign alnum    = is_letter(ch) | is_digit(ch);
  assign keyword  = (run_len == 4'd3) & ~run_ovf &
                    ((text_buf == actok_pkg::KW_LDA) | (text_buf == actok_pkg::KW_RTS));

  // append the current character to the run
  always_comb begin
    app_text = text_buf;
    app_len  = run_len;
    app_ovf  = run_ovf;
    if (run_len < 4'(MAX_TOKEN_CHARS)) begin
      for (int i = 0; i < MAX_TOKEN_CHARS; i++) begin
        if (run_len == 4'(i)) begin
          app_text[8*i +: 8] = ch;
        end
      end
      app_len = run_len + 4'd1;
    end else begin
      app_ovf = 1'b1;
    end
  end

  always_comb begin
    mode_next     = mode;
    text_buf_next = text_buf;
    run_len_next  = run_len;
    run_ovf_next  = run_ovf;
    all_hex_next  = all_hex;
    do_fresh      = 1'b0;
    have_run      = 1'b0;
    have_fresh    = 1'b0;
    run_tok       = '{kind: actok_pkg::KIND_IDENT, length: run_len, overflow: run_ovf,
                      text: text_buf, last: 1'b1};
    fresh_tok     = '{kind: actok_pkg::KIND_INVALID, length: 4'd0, overflow: 1'b0,
                      text: '0, last: 1'b1};

    unique case (mode)
      MODE_WORD, MODE_DOLLAR, MODE_DIGITS: begin
        if (alnum) begin
          text_buf_next = app_text;
          run_len_next  = app_len;
          run_ovf_next  = app_ovf;
          all_hex_next  = all_hex & is_hex(ch);
        end else begin
          have_run      = 1'b1;
          mode_next     = MODE_IDLE;
          text_buf_next = '0;
          run_len_next  = 4'd0;
          run_ovf_next  = 1'b0;
          all_hex_next  = 1'b1;
          do_fresh      = 1'b1;
          if (mode == MODE_WORD) begin
            if (keyword) begin
              run_tok.kind = actok_pkg::KIND_KEYWORD;
            end else if (ch == actok_pkg::CH_COLON) begin
              // label: the colon is consumed
              run_tok.kind = actok_pkg::KIND_LABEL;
              do_fresh     = 1'b0;
            end
          end else if (mode == MODE_DOLLAR) begin
            run_tok.kind = all_hex ? actok_pkg::KIND_CONST : actok_pkg::KIND_INVALID;
          end else begin
            run_tok.kind = actok_pkg::KIND_INVALID;
          end
        end
      end
      MODE_SKIP: begin
        if (ch == actok_pkg::CH_LF) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_IDLE: begin
        do_fresh = 1'b1;
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase

    if (do_fresh) begin
      if (is_space(ch)) begin
        mode_next = MODE_IDLE;
      end else if (ch == actok_pkg::CH_NUL || ch == actok_pkg::CH_SEMI) begin
        mode_next = MODE_SKIP;
      end else if (is_letter(ch) || is_digit(ch)) begin
        mode_next     = is_letter(ch) ? MODE_WORD : MODE_DIGITS;
        text_buf_next = {{(actok_pkg::TEXT_W-8){1'b0}}, ch};
        run_len_next  = 4'd1;
        run_ovf_next  = 1'b0;
        all_hex_next  = is_hex(ch);
      end else if (ch == actok_pkg::CH_DOLLAR) begin
        mode_next     = MODE_DOLLAR;
        text_buf_next = '0;
        run_len_next  = 4'd0;
        run_ovf_next  = 1'b0;
        all_hex_next  = 1'b1;
      end else begin
        mode_next  = MODE_IDLE;
        have_fresh = 1'b1;
        case (ch)
          actok_pkg::CH_LPAREN: fresh_tok.kind = actok_pkg::KIND_LPAREN;
          actok_pkg::CH_RPAREN: fresh_tok.kind = actok_pkg::KIND_RPAREN;
          actok_pkg::CH_COMMA:  fresh_tok.kind = actok_pkg::KIND_COMMA;
          actok_pkg::CH_POUND:  fresh_tok.kind = actok_pkg::KIND_POUND;
          default: begin
            fresh_tok.length = 4'd1;
            fresh_tok.text   = {{(actok_pkg::TEXT_W-8){1'b0}}, ch};
          end
        endcase
      end
    end
  end

  always_comb begin
    push.n  = 2'd0;
    push.t0 = fresh_tok;
    push.t1 = fresh_tok;
    if (have_run) begin
      push.t0      = run_tok;
      push.t0.last = ~have_fresh;
      push.n       = have_fresh ? 2'd2 : 2'd1;
    end else if (have_fresh) begin
      push.n = 2'd1;
    end
    if (!take) begin
      push.n = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      text_buf <= '0;
      run_len  <= 4'd0;
      run_ovf  <= 1'b0;
      all_hex  <= 1'b1;
    end else if (take) begin
      mode     <= mode_next;
      text_buf <= text_buf_next;
      run_len  <= run_len_next;
      run_ovf  <= run_ovf_next;
      all_hex  <= all_hex_next;
    end
  end

  `ASSERT_NEVER(a_skip_silent, clk, rst,
                (mode == MODE_SKIP) && (push.n != 2'd0), "token in skip")
  `ASSERT_ALWAYS(a_idle_clear, clk, rst,
                 (mode == MODE_IDLE) |-> (run_len == 4'd0 && text_buf == '0),
                 "idle run not cleared")
  `ASSERT_ALWAYS(a_len_bound, clk, rst, run_len <= 4'(MAX_TOKEN_CHARS), "run length past capacity")

endmodule

// ===== hw/rtl/actok_queue.sv =====
// Token queue between lexer and output stage: two writes, one read a cycle.
// Depends on actok_pkg and assert_macros.svh.
`include "assert_macros.svh"
module actok_queue (
  input  logic              clk,
  input  logic              rst,
  input  actok_pkg::push_t  push,
  output logic              room,
  output logic              q_valid,
  output actok_pkg::token_t q_tok,
  input  logic              pop
);

  actok_pkg::token_t                entry [actok_pkg::QUEUE_DEPTH];
  logic [actok_pkg::QPTR_W-1:0]     rd_ptr, wr_ptr, wr_ptr1;
  logic [actok_pkg::QCNT_W-1:0]     count, count_next;

  // room for the worst case of two tokens from one character
  assign room    = count <= actok_pkg::QCNT_W'(actok_pkg::QUEUE_DEPTH - 2);
  assign q_valid = count != '0;
  assign q_tok   = entry[rd_ptr];
  assign wr_ptr1 = wr_ptr + actok_pkg::QPTR_W'(1);

  always_comb begin
    count_next = count + actok_pkg::QCNT_W'(push.n) - actok_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr + actok_pkg::QPTR_W'(pop);
      wr_ptr <= wr_ptr + actok_pkg::QPTR_W'(push.n);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      entry[wr_ptr] <= push.t0;
    end
    if (push.n == 2'd2) begin
      entry[wr_ptr1] <= push.t1;
    end
  end

  `ASSERT_ALWAYS(a_no_overrun, clk, rst, (push.n != 2'd0) |-> room, "push without room")
  `ASSERT_ALWAYS(a_count_bound, clk, rst,
                 count <= actok_pkg::QCNT_W'(actok_pkg::QUEUE_DEPTH),
                 "queue count out of range")

endmodule

// ===== hw/rtl/actok_back.sv =====
// Output stage: registers the queue head and holds it until transferred.
// Depends on actok_pkg.
module actok_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  actok_pkg::token_t q_tok,
  output logic              pop,
  output logic              token_valid,
  input  logic              token_ready,
  output actok_pkg::token_t out_tok
);

  assign pop = q_valid & (~token_valid | token_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (pop) begin
      token_valid <= 1'b1;
    end else if (token_ready) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_tok <= q_tok;
    end
  end

endmodule

// ===== hw/rtl/assembler_char_tokenizer_top.sv =====
// Assembler character tokenizer, top level.
// Depends on actok_pkg, actok_front, actok_queue, actok_back.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  input    | ch_valid / ch_ready    | ch
//  output   | token_valid / token_ready | token_kind, token_length,
//           |                        | length_overflow, token_text, last_of_run
//
// One character per cycle is taken while the four-entry token queue has room
// for two tokens; the queue head is registered whenever the output register
// is empty or being taken, so the output can carry one token per cycle.
// Reset (rst, synchronous) returns the lexer to idle and empties the queue.
// A stalled output fills the queue, then ch_ready drops; the lexer keeps its
// run state across stalls.
module assembler_char_tokenizer_top #(
  parameter int MAX_TOKEN_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  ch,
  input  logic        ch_valid,
  output logic        ch_ready,
  output logic [3:0]  token_kind,
  output logic [3:0]  token_length,
  output logic        length_overflow,
  output logic [63:0] token_text,
  output logic        last_of_run,
  output logic        token_valid,
  input  logic        token_ready
);

  actok_pkg::push_t  push;
  actok_pkg::token_t q_tok, out_tok;
  logic              room, q_valid, pop;

  actok_front #(.MAX_TOKEN_CHARS(MAX_TOKEN_CHARS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .ch       (ch),
    .ch_valid (ch_valid),
    .ch_ready (ch_ready),
    .room     (room),
    .push     (push)
  );

  actok_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .room    (room),
    .q_valid (q_valid),
    .q_tok   (q_tok),
    .pop     (pop)
  );

  actok_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_tok       (q_tok),
    .pop         (pop),
    .token_valid (token_valid),
    .token_ready (token_ready),
    .out_tok     (out_tok)
  );

  assign token_kind      = out_tok.kind;
  assign token_length    = out_tok.length;
  assign length_overflow = out_tok.overflow;
  assign token_text      = out_tok.text;
  assign last_of_run     = out_tok.last;

endmodule
